/* rtl/indexed_list_engine_unit_assert.svh */
// assertion macros for the indexed list engine checker
// expects clk and rst_n in the scope where a macro is used
`ifndef INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ILE_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ILE_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/ile_pkg.sv */
// shared types and constants for the indexed list engine
// no dependencies
package ile_pkg;

    localparam int FUNC_W       = 3;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;
    localparam int LEN_W        = 7;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ     = 3'd0,
        FN_INS_HEAD = 3'd1,
        FN_INS_TAIL = 3'd2,
        FN_INS_AT   = 3'd3,
        FN_DELETE   = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_INS_HEAD,
        S_INS_LINK,
        S_INS_FIX,
        S_DEL_HEAD,
        S_DEL_A,
        S_DEL_B,
        S_DEL_C,
        S_DONE
    } state_t;

endpackage

/* rtl/indexed_list_engine_unit.sv */
// indexed list engine top level: sequencer with link and value stores
// depends on ile_pkg
//
// usage
// - input channel in_valid/in_ready carries one request word: func, position, item_value
// - output channel out_valid/out_ready carries one result word per request:
//   read_value, status, length
// - one request at a time; in_ready is high only while the sequencer is idle
// - the link walk makes one read of the link store per cycle,
//   each read after the first addressed straight from the previous read data
// - a finished result sits in the output register; the next request may be
//   accepted while it waits, and that request stalls in its final state until
//   the register frees up
// - reset empties the list at once: nodes are handed out from a fill counter
//   first and from the free list after, so no clearing pass over the stores
// - if the receiver stalls, the result word holds unchanged until taken
module indexed_list_engine_unit
#(
    parameter int CAPACITY = ile_pkg::DEF_CAPACITY
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ile_pkg::FUNC_W-1:0]  func,
    input  logic [ile_pkg::POS_W-1:0]   position,
    input  logic [ile_pkg::VAL_W-1:0]   item_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ile_pkg::VAL_W-1:0]   read_value,
    output logic [ile_pkg::STAT_W-1:0]  status,
    output logic [ile_pkg::LEN_W-1:0]   length
);
    import ile_pkg::*;

    // node address, count and comparison widths
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // node stores
    logic [VAL_W-1:0]  value_mem [CAPACITY];
    logic [ADDR_W-1:0] link_mem  [CAPACITY];

    logic              value_we;
    logic [ADDR_W-1:0] value_waddr;
    logic              value_re;
    logic [ADDR_W-1:0] value_raddr;
    logic [VAL_W-1:0]  value_rdata_reg;

    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [ADDR_W-1:0] link_wdata;
    logic [ADDR_W-1:0] link_raddr;
    logic [ADDR_W-1:0] link_rdata_reg;

    // control state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic              out_valid_reg, out_valid_next;

    // per-request working registers
    func_t             op_reg, op_next;
    logic              zero_reg, zero_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] node_reg, node_next;
    logic [ADDR_W-1:0] steps_reg, steps_next;
    logic              prime_reg, prime_next;
    status_t           res_status_reg, res_status_next;
    logic              res_rd_reg, res_rd_next;

    // result word
    logic [VAL_W-1:0]  read_value_reg, read_value_next;
    status_t           status_reg, status_next;
    logic [LEN_W-1:0]  length_reg, length_next;

    // request decode
    func_t             fn;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  dec_pos;
    logic              full;
    logic              from_free;
    logic [ADDR_W-1:0] alloc_node;
    status_t           dec_status;
    logic              dec_go;
    logic              dec_zero;
    logic [ADDR_W-1:0] dec_steps;
    logic              accept;
    logic              op_is_ins;
    logic              out_load;
    logic [ADDR_W-1:0] walk_node;

    assign fn         = func_t'(func);
    assign pos_ext    = CMP_W'(position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign full       = (count_reg == CNT_W'(CAPACITY));
    // free list holds every node drawn from the fill counter but not in use
    assign from_free  = (fresh_reg != count_reg);
    assign alloc_node = from_free ? free_head_reg : ADDR_W'(fresh_reg);
    assign accept     = in_valid && in_ready;
    assign op_is_ins  = (op_reg != FN_READ) && (op_reg != FN_DELETE);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    // first walk step starts from the head, later ones from the last read
    assign walk_node  = prime_reg ? link_rdata_reg : cur_reg;

    always_comb
    begin
        dec_status = STAT_OK;
        dec_go     = 1'b0;
        dec_pos    = pos_ext;
        unique case (fn)
            FN_READ:
            begin
                if (pos_ext < cnt_ext)
                    dec_go = 1'b1;
                else
                    dec_status = STAT_RANGE;
            end
            FN_INS_HEAD:
            begin
                dec_pos = '0;
                if (full)
                    dec_status = STAT_FULL;
                else
                    dec_go = 1'b1;
            end
            FN_INS_TAIL:
            begin
                dec_pos = cnt_ext;
                if (full)
                    dec_status = STAT_FULL;
                else
                    dec_go = 1'b1;
            end
            FN_INS_AT:
            begin
                // range check ahead of the full check
                if (pos_ext > cnt_ext)
                    dec_status = STAT_RANGE;
                else if (full)
                    dec_status = STAT_FULL;
                else
                    dec_go = 1'b1;
            end
            FN_DELETE:
            begin
                if (pos_ext < cnt_ext)
                    dec_go = 1'b1;
                else
                    dec_status = STAT_RANGE;
            end
            default:
            begin
                dec_status = STAT_OK;
            end
        endcase
        dec_zero  = (dec_pos == '0);
        // reads walk to the node itself, updates to its predecessor
        dec_steps = (fn == FN_READ) ? ADDR_W'(dec_pos) : ADDR_W'(dec_pos - CMP_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!dec_go)
                        state_next = S_DONE;
                    else if (fn == FN_READ)
                        state_next = S_WALK;
                    else if (fn == FN_DELETE)
                        state_next = dec_zero ? S_DEL_HEAD : S_WALK;
                    else if (from_free)
                        state_next = S_ALLOC;
                    else
                        state_next = dec_zero ? S_INS_HEAD : S_WALK;
                end
            end
            S_ALLOC:
            begin
                state_next = zero_reg ? S_INS_HEAD : S_WALK;
            end
            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    if (op_reg == FN_READ)
                        state_next = S_DONE;
                    else if (op_is_ins)
                        state_next = S_INS_LINK;
                    else
                        state_next = S_DEL_A;
                end
            end
            S_INS_HEAD: state_next = S_DONE;
            S_INS_LINK: state_next = S_INS_FIX;
            S_INS_FIX:  state_next = S_DONE;
            S_DEL_HEAD: state_next = S_DONE;
            S_DEL_A:    state_next = S_DEL_B;
            S_DEL_B:    state_next = S_DEL_C;
            S_DEL_C:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb
    begin
        head_next       = head_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        op_next         = op_reg;
        zero_next       = zero_reg;
        cur_next        = cur_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        prime_next      = prime_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        length_next     = length_reg;

        value_we    = 1'b0;
        value_waddr = alloc_node;
        value_re    = 1'b0;
        value_raddr = walk_node;
        link_we     = 1'b0;
        link_waddr  = node_reg;
        link_wdata  = head_reg;
        link_raddr  = walk_node;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = fn;
                    zero_next       = dec_zero;
                    cur_next        = head_reg;
                    steps_next      = dec_steps;
                    prime_next      = 1'b0;
                    res_status_next = dec_status;
                    res_rd_next     = dec_go && (fn == FN_READ);
                    if (dec_go && (fn == FN_DELETE))
                    begin
                        // fetch the successor of the head for a head delete
                        node_next  = head_reg;
                        link_raddr = head_reg;
                    end
                    else if (dec_go && (fn != FN_READ))
                    begin
                        // claim a node and store the value right away
                        node_next   = alloc_node;
                        value_we    = 1'b1;
                        value_waddr = alloc_node;
                        link_raddr  = free_head_reg;
                        if (!from_free)
                            fresh_next = fresh_reg + CNT_W'(1);
                    end
                end
            end
            S_ALLOC:
            begin
                free_head_next = link_rdata_reg;
            end
            S_WALK:
            begin
                cur_next = walk_node;
                if (steps_reg != '0)
                begin
                    link_raddr = walk_node;
                    steps_next = steps_reg - ADDR_W'(1);
                    prime_next = 1'b1;
                end
                else if (op_reg == FN_READ)
                begin
                    value_re    = 1'b1;
                    value_raddr = walk_node;
                end
                else
                begin
                    link_raddr = walk_node;
                end
            end
            S_INS_HEAD:
            begin
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = head_reg;
                head_next  = node_reg;
                count_next = count_reg + CNT_W'(1);
            end
            S_INS_LINK:
            begin
                // new node takes over the predecessor's successor
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = link_rdata_reg;
            end
            S_INS_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = node_reg;
                count_next = count_reg + CNT_W'(1);
            end
            S_DEL_HEAD:
            begin
                head_next      = link_rdata_reg;
                link_we        = 1'b1;
                link_waddr     = node_reg;
                link_wdata     = free_head_reg;
                free_head_next = node_reg;
                count_next     = count_reg - CNT_W'(1);
            end
            S_DEL_A:
            begin
                // victim is the predecessor's successor; fetch its successor
                node_next  = link_rdata_reg;
                link_raddr = link_rdata_reg;
            end
            S_DEL_B:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = link_rdata_reg;
            end
            S_DEL_C:
            begin
                link_we        = 1'b1;
                link_waddr     = node_reg;
                link_wdata     = free_head_reg;
                free_head_next = node_reg;
                count_next     = count_reg - CNT_W'(1);
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    read_value_next = res_rd_reg ? value_rdata_reg : '0;
                    status_next     = res_status_reg;
                    length_next     = LEN_W'(count_reg);
                end
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // value store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (value_we)
            value_mem[value_waddr] <= item_value;
        if (value_re)
            value_rdata_reg <= value_mem[value_raddr];
    end

    // link store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        link_rdata_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        zero_reg       <= zero_next;
        cur_reg        <= cur_next;
        node_reg       <= node_next;
        steps_reg      <= steps_next;
        prime_reg      <= prime_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
        length_reg     <= length_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign length     = length_reg;

endmodule

/* rtl/ile_checker.sv */
// port-level checker for the indexed list engine, bound to the top level
// depends on ile_pkg and indexed_list_engine_unit_assert.svh
`include "indexed_list_engine_unit_assert.svh"

module ile_checker
#(
    parameter int CAPACITY = ile_pkg::DEF_CAPACITY
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [ile_pkg::FUNC_W-1:0]  func,
    input logic [ile_pkg::POS_W-1:0]   position,
    input logic [ile_pkg::VAL_W-1:0]   item_value,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ile_pkg::VAL_W-1:0]   read_value,
    input logic [ile_pkg::STAT_W-1:0]  status,
    input logic [ile_pkg::LEN_W-1:0]   length
);
    import ile_pkg::*;

    // a waiting request word holds
    `ILE_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(func) && $stable(position) && $stable(item_value), "request word changed while waiting")

    // a stalled result word holds
    `ILE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(status) && $stable(length), "result word changed while stalled")

    // a failed request returns a cleared read_value
    `ILE_ASSERT_NOW(a_value_on_read, out_valid && status != STAT_OK, read_value == '0, "value on a failed request")

    // full status only with the list at capacity
    `ILE_ASSERT_NOW(a_full_len, out_valid && status == STAT_FULL, length == LEN_W'(CAPACITY), "full status below capacity")

    // length never beyond capacity
    `ILE_ASSERT_NOW(a_len_bound, out_valid, int'(length) <= CAPACITY, "length beyond capacity")

endmodule

bind indexed_list_engine_unit ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (.*);

/* tb/indexed_list_engine_unit_tb.sv */
// self-checking testbench for the indexed list engine: random and directed list requests
// keeps its own linked-list model and checks every result word field by field
// depends on ile_pkg and the indexed_list_engine_unit rtl
`timescale 1ns / 100ps

module indexed_list_engine_unit_tb;

    import ile_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CAP         = DEF_CAPACITY;
    localparam int LINK_W      = $clog2(CAP);
    localparam int TOTAL_WORDS = 550;
    // no random gaps or stalls on either side once this few requests are left
    localparam int TAIL_WORDS  = 50;
    // margin after the last result, so a stray late word would still show up
    localparam int SETTLE_CYCLES = CAP + 16;
    // upper bound on the time for a whole run
    localparam int TIMEOUT_NS  = 5_000_000;

    // operation codes the package leaves unnamed; the engine must ignore them
    localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

    // mix of operations in a random stretch
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        bit                drain_first;
    } list_request_t;

    typedef struct {
        logic [VAL_W-1:0] read_value;
        status_t          status;
        logic [LEN_W-1:0] length;
    } list_result_t;

    // every signal the bench drives starts at a known value
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func       = '0;
    logic [POS_W-1:0]    position   = '0;
    logic [VAL_W-1:0]    item_value = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [VAL_W-1:0]    read_value;
    logic [STAT_W-1:0]   status;
    logic [LEN_W-1:0]    length;

    // request words still to send and result words still owed
    list_request_t pending_requests[$];
    list_result_t  expected_results[$];

    // model of the list: node payloads, next links, list and free heads
    logic [VAL_W-1:0]  node_data [CAP];
    logic [LINK_W-1:0] next_node [CAP];
    logic [LINK_W-1:0] list_head;
    logic [LINK_W-1:0] free_list_head;
    int unsigned       stored_count;

    // length as the stimulus generator expects it, so positions can be aimed
    int unsigned planned_length;

    int unsigned words_accepted;
    int unsigned results_checked;
    int unsigned range_rejects;
    int unsigned full_rejects;
    int unsigned peak_length;
    int unsigned error_count;
    int unsigned total_words;

    int unsigned   send_gap;
    int unsigned   recv_stall;
    list_request_t next_request;
    list_result_t  oldest_result;

    indexed_list_engine_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .length     (length)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // list model
    // ------------------------------------------------------------------

    // node reached by following steps links from the head
    function automatic logic [LINK_W-1:0] node_at(input int unsigned steps);
        logic [LINK_W-1:0] n;
        n = list_head;
        for (int unsigned i = 0; i < steps; i++)
            n = next_node[n];
        return n;
    endfunction

    // take a node off the free list and splice it in before pos
    function automatic void link_new_node(input int unsigned pos, input logic [VAL_W-1:0] v);
        logic [LINK_W-1:0] fresh;
        logic [LINK_W-1:0] prev;
        fresh          = free_list_head;
        free_list_head = next_node[fresh];
        node_data[fresh] = v;
        if (pos == 0)
        begin
            next_node[fresh] = list_head;
            list_head        = fresh;
        end
        else
        begin
            prev             = node_at(pos - 1);
            next_node[fresh] = next_node[prev];
            next_node[prev]  = fresh;
        end
        stored_count++;
    endfunction

    // apply one accepted request to the model and queue the result it owes
    function automatic void apply_list_request(input logic [FUNC_W-1:0] fn,
                                               input logic [POS_W-1:0] pos,
                                               input logic [VAL_W-1:0] v);
        list_result_t      r;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] gone;
        bit                full;
        r.read_value = '0;
        r.status     = STAT_OK;
        full         = (stored_count >= CAP);
        case (fn)
            FN_READ:
                if (pos < stored_count)
                    r.read_value = node_data[node_at(pos)];
                else
                    r.status = STAT_RANGE;
            FN_INS_HEAD:
                if (full)
                    r.status = STAT_FULL;
                else
                    link_new_node(0, v);
            FN_INS_TAIL:
                if (full)
                    r.status = STAT_FULL;
                else
                    link_new_node(stored_count, v);
            FN_INS_AT:
                // past-the-end wins over full
                if (pos > stored_count)
                    r.status = STAT_RANGE;
                else if (full)
                    r.status = STAT_FULL;
                else
                    link_new_node(pos, v);
            FN_DELETE:
                if (pos < stored_count)
                begin
                    if (pos == 0)
                    begin
                        gone      = list_head;
                        list_head = next_node[gone];
                    end
                    else
                    begin
                        prev            = node_at(pos - 1);
                        gone            = next_node[prev];
                        next_node[prev] = next_node[gone];
                    end
                    next_node[gone] = free_list_head;
                    free_list_head  = gone;
                    stored_count--;
                end
                else
                    r.status = STAT_RANGE;
            default:
                ;
        endcase
        r.length = stored_count[LEN_W-1:0];
        if (r.status == STAT_RANGE)
            range_rejects++;
        if (r.status == STAT_FULL)
            full_rejects++;
        if (stored_count > peak_length)
            peak_length = stored_count;
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // queue a request and track the length it leaves behind
    function automatic void queue_request(input logic [FUNC_W-1:0] fn, input int unsigned pos,
                                          input logic [VAL_W-1:0] v, input bit drain);
        list_request_t q;
        q.fn          = fn;
        q.pos         = pos[POS_W-1:0];
        q.val         = v;
        q.drain_first = drain;
        pending_requests.push_back(q);
        case (fn)
            FN_INS_HEAD, FN_INS_TAIL:
                if (planned_length < CAP)
                    planned_length++;
            FN_INS_AT:
                if (q.pos <= planned_length && planned_length < CAP)
                    planned_length++;
            FN_DELETE:
                if (q.pos < planned_length)
                    planned_length--;
            default:
                ;
        endcase
    endfunction

    // position in [0, span-1], leaning on both ends
    function automatic int unsigned pick_position(input int unsigned span);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return span - 1;
            default: return $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: presents request words from the pending queue
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FN_READ;
            position   <= '0;
            item_value <= '0;
            send_gap   = 0;
        end
        else
        begin
            // word taken at this edge: the model sees exactly what the engine saw
            if (in_valid && in_ready)
            begin
                apply_list_request(func, position, item_value);
                words_accepted++;
            end
            // the channel is free unless a word is still waiting to be taken
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_requests[0].drain_first && expected_results.size() != 0)
                    // hold off until every owed result has come back
                    in_valid <= 1'b0;
                else if (pending_requests.size() >= TAIL_WORDS && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(1, 18) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_request = pending_requests.pop_front();
                    in_valid   <= 1'b1;
                    func       <= next_request.fn;
                    position   <= next_request.pos;
                    item_value <= next_request.val;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: stalls the result channel and checks each result word
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result word with nothing owed: value %h status %0d length %0d",
                                              read_value, status, length));
                else
                begin
                    oldest_result = expected_results.pop_front();
                    results_checked++;
                    if (read_value !== oldest_result.read_value)
                        report_mismatch($sformatf("result %0d read_value %h, model %h", results_checked,
                                                  read_value, oldest_result.read_value));
                    if (status !== oldest_result.status)
                        report_mismatch($sformatf("result %0d status %0d, model %0d", results_checked,
                                                  status, oldest_result.status));
                    if (length !== oldest_result.length)
                        report_mismatch($sformatf("result %0d length %0d, model %0d", results_checked,
                                                  length, oldest_result.length));
                end
            end
            // stalls come in bursts and stop for the last stretch of the run
            if (recv_stall != 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (pending_requests.size() >= TAIL_WORDS && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(1, 18) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned   mix;
        int unsigned   stretch;
        int unsigned   pick;
        logic [FUNC_W-1:0] fn;

        // model state after reset: empty list, free list chained in order
        for (int i = 0; i < CAP; i++)
        begin
            node_data[i] = '0;
            next_node[i] = LINK_W'((i + 1) % CAP);
        end
        list_head       = '0;
        free_list_head  = '0;
        stored_count    = 0;
        planned_length  = 0;
        words_accepted  = 0;
        results_checked = 0;
        range_rejects   = 0;
        full_rejects    = 0;
        peak_length     = 0;
        error_count     = 0;

        // directed: empty-list rejects
        queue_request(FN_READ,   0, '0, 1'b0);
        queue_request(FN_DELETE, 0, '0, 1'b0);
        queue_request(FN_INS_AT, 1, 32'h1234_5678, 1'b0);
        // tail insert into an empty list, then each insert flavour
        queue_request(FN_INS_TAIL, 0, 32'h8000_0000, 1'b0);
        queue_request(FN_READ,     0, '0, 1'b0);
        queue_request(FN_INS_HEAD, 0, 32'h7FFF_FFFF, 1'b0);
        queue_request(FN_INS_AT,   1, '1, 1'b0);
        queue_request(FN_INS_AT,   3, '0, 1'b0);          // position equal to length appends
        queue_request(FN_INS_AT,   0, 32'h0000_0001, 1'b0);
        queue_request(FN_READ,     4, '0, 1'b0);
        queue_request(FN_READ,     2, '0, 1'b0);
        queue_request(FN_READ,     5, '0, 1'b0);          // one past the end
        // unused codes change nothing
        queue_request(FN_SPARE_LO,  127, $urandom, 1'b0);
        queue_request(FN_SPARE_MID, 0,   '1, 1'b0);
        queue_request(FN_SPARE_HI,  64,  32'h8000_0000, 1'b0);
        // largest position on every positional operation
        queue_request(FN_READ,   127, '0, 1'b0);
        queue_request(FN_DELETE, 127, '0, 1'b0);
        queue_request(FN_INS_AT, 127, 32'hDEAD_BEEF, 1'b0);
        // delete from the middle, the head and the tail, then empty out
        queue_request(FN_DELETE, 2, '0, 1'b0);
        queue_request(FN_DELETE, 0, '0, 1'b0);
        queue_request(FN_DELETE, 2, '0, 1'b0);
        queue_request(FN_READ,   0, '0, 1'b0);
        queue_request(FN_READ,   1, '0, 1'b0);
        queue_request(FN_DELETE, 0, '0, 1'b0);
        queue_request(FN_DELETE, 0, '0, 1'b0);

        // fill to capacity after a full drain, then probe the full list
        while (planned_length < CAP)
        begin
            fn = FUNC_W'($urandom_range(FN_INS_HEAD, FN_INS_AT));
            queue_request(fn, pick_position(planned_length + 1), pick_value(),
                          planned_length == 0);
        end
        queue_request(FN_INS_HEAD, 0,       pick_value(), 1'b0);
        queue_request(FN_INS_TAIL, 0,       pick_value(), 1'b0);
        queue_request(FN_INS_AT,   CAP,     pick_value(), 1'b0);
        queue_request(FN_INS_AT,   100,     pick_value(), 1'b0);  // range checked before full
        queue_request(FN_READ,     CAP - 1, '0, 1'b0);
        queue_request(FN_READ,     CAP,     '0, 1'b0);
        queue_request(FN_DELETE,   CAP - 1, '0, 1'b0);
        queue_request(FN_INS_AT,   CAP - 1, pick_value(), 1'b0);
        queue_request(FN_DELETE,   0,       '0, 1'b0);

        // random stretches, each leaning towards growth, shrinkage or neither
        while (pending_requests.size() < TOTAL_WORDS)
        begin
            mix     = $urandom_range(MIX_GROW, MIX_EVEN);
            stretch = $urandom_range(15, 60);
            for (int unsigned k = 0; k < stretch && pending_requests.size() < TOTAL_WORDS; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: any code, any position
                    queue_request(FUNC_W'($urandom_range(FN_READ, FN_SPARE_HI)),
                                  $urandom_range(0, 127),
                                  $urandom, k == 0 && $urandom_range(0, 3) == 0);
                    continue;
                end
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:
                        fn = pick < 15 ? FN_READ : pick < 30 ? FN_INS_HEAD :
                             pick < 50 ? FN_INS_TAIL : pick < 75 ? FN_INS_AT : FN_DELETE;
                    MIX_SHRINK:
                        fn = pick < 20 ? FN_READ : pick < 27 ? FN_INS_HEAD :
                             pick < 34 ? FN_INS_TAIL : pick < 45 ? FN_INS_AT : FN_DELETE;
                    default:
                        fn = pick < 30 ? FN_READ : pick < 45 ? FN_INS_HEAD :
                             pick < 60 ? FN_INS_TAIL : pick < 80 ? FN_INS_AT : FN_DELETE;
                endcase
                if (fn == FN_INS_AT)
                    queue_request(fn, pick_position(planned_length + 1), pick_value(),
                                  k == 0 && $urandom_range(0, 3) == 0);
                else
                    queue_request(fn, planned_length == 0 ? 0 : pick_position(planned_length),
                                  pick_value(), k == 0 && $urandom_range(0, 3) == 0);
            end
        end
        total_words = pending_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted != total_words)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // give a stray extra word time to show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d result words: %0d out-of-range and %0d full rejects,",
                 words_accepted, results_checked, range_rejects, full_rejects);
        $display("list length peaked at %0d of %0d nodes.", peak_length, CAP);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d of %0d requests taken and %0d results owed",
                 words_accepted, total_words, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
